@@ hw/rtl/broadcast_message_ring_core_defines.svh @@
// assertion helpers for the checker file
`ifndef BROADCAST_MESSAGE_RING_CORE_DEFINES_SVH
`define BROADCAST_MESSAGE_RING_CORE_DEFINES_SVH

// consequent holds in the same cycle
`define BMR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the next cycle
`define BMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/bmr_pkg.sv @@
`default_nettype none
package bmr_pkg;

  localparam int RingAw    = 12;
  localparam int Readers   = 8;
  localparam int MsgMax    = 64;
  localparam int StageAw   = 6;
  localparam int HdrBytes  = 12;

  typedef logic [2:0] status_t;
  localparam status_t ST_BYTE     = 3'd0;
  localparam status_t ST_WRITTEN  = 3'd1;
  localparam status_t ST_EMPTY    = 3'd2;
  localparam status_t ST_BAD_MAG  = 3'd3;
  localparam status_t ST_BAD_SUM  = 3'd4;
  localparam status_t ST_SMALL    = 3'd5;
  localparam status_t ST_LONG     = 3'd6;
  localparam status_t ST_DISABLED = 3'd7;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [2:0]  reader;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] out_capacity;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic [6:0]  msg_length;
  } out_item_t;

  // header byte of a freshly written frame
  function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [6:0] plen);
    logic [8:0] sum;
    logic [7:0] b;
    sum = 9'h124 + {2'b00, plen};
    case (idx)
      4'd0:    b = 8'h4F;
      4'd1:    b = 8'h46;
      4'd2:    b = 8'h49;
      4'd3:    b = 8'h46;
      4'd4:    b = {1'b0, plen};
      4'd8:    b = sum[7:0];
      4'd9:    b = {7'd0, sum[8]};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bmr_ring_ram.sv @@
`default_nettype none
module bmr_ring_ram (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [bmr_pkg::RingAw-1:0] addr_i,
  input  wire logic [7:0]               wdata_i,
  output logic [7:0]                    rdata_o
);
  import bmr_pkg::*;

  logic [7:0] mem [2**RingAw];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

@@ hw/rtl/bmr_stage_ram.sv @@
`default_nettype none
module bmr_stage_ram (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [bmr_pkg::StageAw-1:0] waddr_i,
  input  wire logic [7:0]                wdata_i,
  input  wire logic                      re_i,
  input  wire logic [bmr_pkg::StageAw-1:0] raddr_i,
  output logic [7:0]                     rdata_o
);
  import bmr_pkg::*;

  logic [7:0] mem [2**StageAw];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

@@ hw/rtl/broadcast_message_ring_core.sv @@
// broadcast message ring: framed messages in a 4096-byte ring, up to eight readers
// input channel: in_valid_i / in_stall_o carry one request per accepted item
//   write request (mode 0) stages one payload byte, no result;
//   its last byte commits: readers short of room are pushed over whole frames,
//   then header and payload are written at one byte per cycle, then one status
//   result (ST_LONG instead if the message was over 64 bytes)
// read request (mode 1): header fetched and checked, then each payload byte is
//   read, sent, then the next; last_of_run ends the run; single status otherwise
// all ring traffic goes through one single-port ram with a registered read;
//   one request is worked on at a time
// output channel: out_valid_o / out_stall_i with a result register; a stalled
//   result holds, the byte run simply pauses, and a new request is taken
//   while the last result still waits
// cfg_we_i writes the reader enable mask; a newly set bit puts that reader at
//   the write position; write only while idle
// reset clears positions, staging and mask; the ring itself is not cleared
`default_nettype none
module broadcast_message_ring_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire bmr_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output bmr_pkg::out_item_t      out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_data_i
);
  import bmr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_HDR, S_WALK, S_WR, S_EMIT, S_RD_EVAL, S_RD_ISSUE, S_RD_DATA
  } state_e;

  state_e            state_q;
  logic [RingAw-1:0] wp_q, lfs_q, hbase_q, rbase_q, shp_q;
  logic [RingAw-1:0] pos_q [Readers];
  logic [7:0]        en_q;
  logic [6:0]        cnt_q, plen_q, wk_q, rk_q, hl_q, drop_q, amount_q;
  logic              ovf_q, shv_q, walk_q;
  logic [2:0]        ri_q, rd_q;
  logic [3:0]        hk_q;
  logic [15:0]       cap_q;
  logic [7:0]        hdr_q [HdrBytes];
  out_item_t         res_q, out_q;
  logic              out_valid_q;

  logic              ring_we, ring_re, stage_re;
  logic [RingAw-1:0] ring_addr;
  logic [7:0]        ring_wdata, ring_rdata, stage_rdata;
  logic [StageAw-1:0] stage_raddr;

  logic              accept, out_free, out_load;
  logic              magic_ok, sum_ok;
  logic [10:0]       hsum;
  logic [31:0]       hlen;
  status_t           hstat;
  logic [33:0]       step;
  logic              walk_done;
  logic [RingAw-1:0] next_r, fr;
  logic [6:0]        need;
  logic              scan_last;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = out_free && ((state_q == S_EMIT) || (state_q == S_RD_DATA));
  assign need     = 7'(HdrBytes) + plen_q;
  assign fr       = pos_q[ri_q] - wp_q - RingAw'(1);
  assign scan_last = (ri_q == 3'(Readers - 1));

  always_comb begin
    magic_ok = (hdr_q[0] == 8'h4F) && (hdr_q[1] == 8'h46) &&
               (hdr_q[2] == 8'h49) && (hdr_q[3] == 8'h46);
    hsum = '0;
    for (int k = 0; k < 8; k++) begin
      hsum = hsum + {3'b000, hdr_q[k]};
    end
    sum_ok = ({21'd0, hsum} == {hdr_q[11], hdr_q[10], hdr_q[9], hdr_q[8]});
    hlen   = {hdr_q[7], hdr_q[6], hdr_q[5], hdr_q[4]};
    if (!magic_ok) begin
      hstat = ST_BAD_MAG;
    end else if (!sum_ok) begin
      hstat = ST_BAD_SUM;
    end else begin
      hstat = ST_BYTE;
    end
    step      = {27'd0, drop_q} + 34'(HdrBytes) + {2'b00, hlen};
    walk_done = (step >= {27'd0, amount_q});
    next_r    = hbase_q + RingAw'(HdrBytes) + hlen[RingAw-1:0];
  end

  always_comb begin
    ring_we     = 1'b0;
    ring_re     = 1'b0;
    ring_addr   = wp_q;
    ring_wdata  = stage_rdata;
    stage_re    = 1'b0;
    stage_raddr = '0;
    case (state_q)
      S_HDR: begin
        ring_re   = (hk_q < 4'(HdrBytes));
        ring_addr = hbase_q + RingAw'(hk_q);
      end
      S_WR: begin
        ring_we     = 1'b1;
        ring_addr   = wp_q + RingAw'(wk_q);
        ring_wdata  = (wk_q < 7'(HdrBytes)) ? hdr_byte(wk_q[3:0], plen_q) : stage_rdata;
        stage_re    = 1'b1;
        stage_raddr = 6'(wk_q - 7'(HdrBytes - 1));
      end
      S_RD_ISSUE: begin
        ring_re   = 1'b1;
        ring_addr = rbase_q + RingAw'(rk_q);
      end
      default: ;
    endcase
  end

  bmr_ring_ram u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .re_i    (ring_re),
    .addr_i  (ring_addr),
    .wdata_i (ring_wdata),
    .rdata_o (ring_rdata)
  );

  bmr_stage_ram u_stage (
    .clk_i   (clk_i),
    .we_i    (accept && (in_data_i.mode == MODE_WRITE) && (cnt_q < 7'(MsgMax))),
    .waddr_i (cnt_q[StageAw-1:0]),
    .wdata_i (in_data_i.data_byte),
    .re_i    (stage_re),
    .raddr_i (stage_raddr),
    .rdata_o (stage_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      lfs_q       <= '0;
      hbase_q     <= '0;
      rbase_q     <= '0;
      shp_q       <= '0;
      for (int i = 0; i < Readers; i++) pos_q[i] <= '0;
      for (int i = 0; i < HdrBytes; i++) hdr_q[i] <= '0;
      en_q        <= '0;
      cnt_q       <= '0;
      plen_q      <= '0;
      wk_q        <= '0;
      rk_q        <= '0;
      hl_q        <= '0;
      drop_q      <= '0;
      amount_q    <= '0;
      ovf_q       <= 1'b0;
      shv_q       <= 1'b0;
      walk_q      <= 1'b0;
      ri_q        <= '0;
      rd_q        <= '0;
      hk_q        <= '0;
      cap_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        for (int i = 0; i < Readers; i++) begin
          if (cfg_data_i[i] && !en_q[i]) pos_q[i] <= wp_q;
        end
        en_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cap_q <= in_data_i.out_capacity;
            rd_q  <= in_data_i.reader;
            if (in_data_i.mode == MODE_WRITE) begin
              if (in_data_i.last_byte) begin
                plen_q <= (cnt_q < 7'(MsgMax)) ? cnt_q + 7'd1 : cnt_q;
                cnt_q  <= '0;
                ovf_q  <= 1'b0;
                if (ovf_q || (cnt_q == 7'(MsgMax))) begin
                  res_q   <= '{ST_LONG, 8'd0, 1'b1, 7'(MsgMax)};
                  state_q <= S_EMIT;
                end else begin
                  ri_q    <= '0;
                  shv_q   <= 1'b0;
                  state_q <= S_SCAN;
                end
              end else if (cnt_q < 7'(MsgMax)) begin
                cnt_q <= cnt_q + 7'd1;
              end else begin
                ovf_q <= 1'b1;
              end
            end else if (!en_q[in_data_i.reader]) begin
              res_q   <= '{ST_DISABLED, 8'd0, 1'b1, 7'd0};
              state_q <= S_EMIT;
            end else if (pos_q[in_data_i.reader] == wp_q) begin
              res_q   <= '{ST_EMPTY, 8'd0, 1'b1, 7'd0};
              state_q <= S_EMIT;
            end else begin
              hbase_q <= pos_q[in_data_i.reader];
              walk_q  <= 1'b0;
              hk_q    <= '0;
              state_q <= S_HDR;
            end
          end
        end
        S_SCAN: begin
          if (en_q[ri_q] && (fr < RingAw'(need)) && !shv_q) begin
            hbase_q  <= pos_q[ri_q];
            drop_q   <= '0;
            amount_q <= need - fr[6:0];
            walk_q   <= 1'b1;
            hk_q     <= '0;
            state_q  <= S_HDR;
          end else begin
            if (en_q[ri_q] && (fr < RingAw'(need))) pos_q[ri_q] <= shp_q;
            if (scan_last) begin
              wk_q    <= '0;
              state_q <= S_WR;
            end else begin
              ri_q <= ri_q + 3'd1;
            end
          end
        end
        S_HDR: begin
          if (hk_q != 4'd0) hdr_q[hk_q - 4'd1] <= ring_rdata;
          if (hk_q == 4'(HdrBytes)) begin
            state_q <= walk_q ? S_WALK : S_RD_EVAL;
          end else begin
            hk_q <= hk_q + 4'd1;
          end
        end
        S_WALK: begin
          if ((hstat != ST_BYTE) || walk_done) begin
            // bad header falls back to the last frame start and is not shared
            if (hstat != ST_BYTE) begin
              pos_q[ri_q] <= lfs_q;
            end else begin
              pos_q[ri_q] <= next_r;
              shv_q       <= 1'b1;
              shp_q       <= next_r;
            end
            if (scan_last) begin
              wk_q    <= '0;
              state_q <= S_WR;
            end else begin
              ri_q    <= ri_q + 3'd1;
              state_q <= S_SCAN;
            end
          end else begin
            drop_q  <= step[6:0];
            hbase_q <= next_r;
            hk_q    <= '0;
            state_q <= S_HDR;
          end
        end
        S_WR: begin
          if (wk_q == need - 7'd1) begin
            lfs_q   <= wp_q;
            wp_q    <= wp_q + RingAw'(need);
            res_q   <= '{ST_WRITTEN, 8'd0, 1'b1, plen_q};
            state_q <= S_EMIT;
          end else begin
            wk_q <= wk_q + 7'd1;
          end
        end
        S_RD_EVAL: begin
          if (hstat != ST_BYTE) begin
            pos_q[rd_q] <= lfs_q;
            res_q       <= '{hstat, 8'd0, 1'b1, 7'd0};
            state_q     <= S_EMIT;
          end else if ((hlen > {16'd0, cap_q}) || (hlen > 32'(MsgMax))) begin
            res_q   <= '{ST_SMALL, 8'd0, 1'b1, (hlen > 32'd127) ? 7'd127 : hlen[6:0]};
            state_q <= S_EMIT;
          end else if (hlen == 32'd0) begin
            pos_q[rd_q] <= hbase_q + RingAw'(HdrBytes);
            res_q       <= '{ST_EMPTY, 8'd0, 1'b1, 7'd0};
            state_q     <= S_EMIT;
          end else begin
            rbase_q <= hbase_q + RingAw'(HdrBytes);
            rk_q    <= '0;
            hl_q    <= hlen[6:0];
            state_q <= S_RD_ISSUE;
          end
        end
        S_RD_ISSUE: begin
          state_q <= S_RD_DATA;
        end
        S_RD_DATA: begin
          if (out_free) begin
            out_q       <= '{ST_BYTE, ring_rdata, (rk_q + 7'd1 == hl_q), hl_q};
            out_valid_q <= 1'b1;
            rk_q        <= rk_q + 7'd1;
            if (rk_q + 7'd1 == hl_q) begin
              pos_q[rd_q] <= rbase_q + RingAw'(hl_q);
              state_q     <= S_IDLE;
            end else begin
              state_q <= S_RD_ISSUE;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule
`default_nettype wire

@@ hw/rtl/bmr_checker.sv @@
`default_nettype none
`include "broadcast_message_ring_core_defines.svh"
module bmr_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire bmr_pkg::in_item_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire bmr_pkg::out_item_t out_data_o
);
  import bmr_pkg::*;

  // a stalled result holds
  `BMR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // after staging a byte the block can accept again in the next cycle
  `BMR_ASSERT_NEXT(a_stage_fast, clk_i, rst_ni, in_valid_i && !in_stall_o && (in_data_i.mode == MODE_WRITE) && !in_data_i.last_byte, !in_stall_o)

  // every read request makes the block busy in the next cycle
  `BMR_ASSERT_NEXT(a_read_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && (in_data_i.mode == MODE_READ), in_stall_o)

  // only payload bytes can continue a run
  `BMR_ASSERT_NOW(a_run_bytes, clk_i, rst_ni, out_valid_o && !out_data_o.last_of_run, out_data_o.status == ST_BYTE)
endmodule

bind broadcast_message_ring_core bmr_checker u_bmr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
